>>> hdl/odo_pkg.sv
// Package for the heading-fused odometry integrator.
// Holds widths, reset values, register indexes, the sequencer state type and the
// CORDIC arctangent table. No dependencies.
`default_nettype none

package odo_pkg;

   // Field and register widths
   localparam int unsigned COUNT_W     = 32;
   localparam int unsigned HEADING_W   = 16;
   localparam int unsigned POS_W       = 32;
   localparam int unsigned MPC_W       = 32;
   localparam int unsigned LIMIT_W     = 16;
   localparam int unsigned CSR_INDEX_W = 4;
   localparam int unsigned CSR_DATA_W  = 32;

   // Internal datapath widths
   localparam int unsigned DELTA_W     = 17;                    // gated count delta
   localparam int unsigned DSUM_W      = 18;                    // left + right delta
   localparam int unsigned TRIG_W      = 33;                    // cos/sin, Q1.30 plus headroom
   localparam int unsigned ANGLE_W     = 34;                    // residual angle, 2^-32 turns
   localparam int unsigned ATAN_IDX_W  = 5;
   localparam int unsigned PATH_A_W    = MPC_W + 1;             // scale, zero-extended
   localparam int unsigned PATH_P_W    = PATH_A_W + DSUM_W;     // delta sum times scale
   localparam int unsigned PATH_SHIFT  = 17;
   localparam int unsigned PATH_S_W    = PATH_P_W - PATH_SHIFT; // path length, Q16.16
   localparam int unsigned PROJ_P_W    = TRIG_W + PATH_S_W;     // length times cos/sin
   localparam int unsigned PROJ_SHIFT  = 30;
   localparam int unsigned DISP_W      = PROJ_P_W - PROJ_SHIFT; // displacement, Q16.16
   localparam int unsigned SUM_W       = DISP_W + 1;

   localparam int unsigned CORDIC_STAGES_DEF = 16;

   // Register reset values
   localparam logic [MPC_W-1:0]   MPC_RESET   = 32'd42950;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd15000;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_METERS_PER_COUNT = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COUNT_JUMP_LIMIT = 4'd1;

   // Arithmetic constants
   localparam logic signed [TRIG_W-1:0]   CORDIC_GAIN  = 33'sd652032874;
   localparam logic signed [ANGLE_W-1:0]  QUARTER_TURN = 34'sd1073741824;
   localparam logic signed [ANGLE_W-1:0]  HALF_TURN    = 34'sd2147483648;
   localparam logic signed [PATH_P_W-1:0] PATH_ROUND   = 51'sd65536;
   localparam logic signed [PROJ_P_W-1:0] PROJ_ROUND   = 67'sd536870912;
   localparam logic signed [SUM_W-1:0]    POS_MAX      = 38'sd2147483647;
   localparam logic signed [SUM_W-1:0]    POS_MIN      = -38'sd2147483648;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_GATE,
      ST_PATH_GO,
      ST_PATH_RUN,
      ST_ROUND,
      ST_PROJ_GO,
      ST_PROJ_RUN,
      ST_SCALE,
      ST_SAT,
      ST_EMIT
   } odo_state_type;

   // Arctangent of 2^-i in 2^-32 turns
   function automatic logic [31:0] atan_turns(input logic [ATAN_IDX_W-1:0] idx);
      logic [31:0] val;
      unique case (idx)
         5'd0:    val = 32'd536870912;
         5'd1:    val = 32'd316933405;
         5'd2:    val = 32'd167458907;
         5'd3:    val = 32'd85004756;
         5'd4:    val = 32'd42667331;
         5'd5:    val = 32'd21354465;
         5'd6:    val = 32'd10679838;
         5'd7:    val = 32'd5340245;
         5'd8:    val = 32'd2670163;
         5'd9:    val = 32'd1335086;
         5'd10:   val = 32'd667544;
         5'd11:   val = 32'd333772;
         5'd12:   val = 32'd166886;
         5'd13:   val = 32'd83443;
         5'd14:   val = 32'd41721;
         5'd15:   val = 32'd20860;
         5'd16:   val = 32'd10430;
         5'd17:   val = 32'd5215;
         5'd18:   val = 32'd2607;
         5'd19:   val = 32'd1303;
         5'd20:   val = 32'd651;
         5'd21:   val = 32'd325;
         5'd22:   val = 32'd162;
         5'd23:   val = 32'd81;
         default: val = 32'd0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

>>> hdl/odo_mul_serial.sv
// Digit-serial signed multiplier, two multiplier bits per cycle.
// The multiplier shifts out of the low half while partial sums shift in.
// Self-contained; sized entirely by its parameters.
`default_nettype none

module odo_mul_serial #(
   parameter int unsigned NA = 33,   // multiplicand width, signed
   parameter int unsigned NB = 18    // multiplier width, signed, even
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic signed [NA-1:0]    a,
   input  wire logic signed [NB-1:0]    b,
   output logic                         done,
   output logic signed [NA+NB-1:0]      product
);

   localparam int unsigned HW   = NA + 3;
   localparam int unsigned NDIG = NB / 2;
   localparam int unsigned CW   = (NDIG > 1) ? $clog2(NDIG) : 1;

   logic signed [NA-1:0] a_ff, a_in;
   logic signed [HW-1:0] hi_ff, hi_in;
   logic [NB-1:0]        lo_ff, lo_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   logic signed [HW-1:0] a_ext, a_dbl, pp, acc;
   logic                 top_digit;

   // Form the partial product of one radix-4 digit; the last digit is signed
   always_comb begin
      a_ext     = $signed({{3{a_ff[NA-1]}}, a_ff});
      a_dbl     = a_ext <<< 1;
      top_digit = (cnt_ff == CW'(NDIG - 1));
      pp        = '0;
      if (lo_ff[0]) begin
         pp = a_ext;
      end
      if (lo_ff[1]) begin
         pp = top_digit ? (pp - a_dbl) : (pp + a_dbl);
      end
      acc = hi_ff + pp;
   end

   // Load on start, then add and shift one digit a cycle
   always_comb begin
      a_in    = a_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         a_in    = a;
         hi_in   = '0;
         lo_in   = b;
         cnt_in  = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         hi_in  = acc >>> 2;
         lo_in  = {acc[1:0], lo_ff[NB-1:2]};
         cnt_in = cnt_ff + 1'b1;
         if (top_digit) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff  <= a_in;
      hi_ff <= hi_in;
      lo_ff <= lo_in;
   end

   assign done    = done_ff;
   assign product = $signed({hi_ff[NA-1:0], lo_ff});

endmodule

`default_nettype wire

>>> hdl/odo_cordic.sv
// Rotation-mode CORDIC, one micro-rotation per cycle on a shared add/shift unit.
// Gives cos and sin of a 16-bit binary angle in Q1.30.
// Depends on odo_pkg (widths, gain, turn constants, arctangent table).
`default_nettype none

module odo_cordic
   import odo_pkg::*;
#(
   parameter int unsigned STAGES = CORDIC_STAGES_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic signed [HEADING_W-1:0] angle,
   output logic                             done,
   output logic signed [TRIG_W-1:0]         cos_out,
   output logic signed [TRIG_W-1:0]         sin_out
);

   localparam int unsigned IW = (STAGES > 1) ? $clog2(STAGES) : 1;

   logic signed [TRIG_W-1:0]  x_ff, x_in, y_ff, y_in;
   logic signed [ANGLE_W-1:0] z_ff, z_in;
   logic [IW-1:0]             iter_ff, iter_in;
   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;

   logic signed [ANGLE_W-1:0] z_start, atan_step;
   logic signed [TRIG_W-1:0]  x_shift, y_shift;

   // Angle in 2^-32 turns, shifted copies and the table step for this iteration
   always_comb begin
      z_start   = $signed({{(ANGLE_W - HEADING_W - 16){angle[HEADING_W-1]}}, angle, 16'b0});
      x_shift   = x_ff >>> iter_ff;
      y_shift   = y_ff >>> iter_ff;
      atan_step = $signed({{(ANGLE_W - 32){1'b0}}, atan_turns(ATAN_IDX_W'(iter_ff))});
   end

   // Fold into the right half plane on start, then rotate toward zero angle
   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      iter_in = iter_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         iter_in = '0;
         y_in    = '0;
         if (z_start > QUARTER_TURN || z_start < -QUARTER_TURN) begin
            x_in = -CORDIC_GAIN;
            z_in = z_start[ANGLE_W-1] ? (z_start + HALF_TURN) : (z_start - HALF_TURN);
         end else begin
            x_in = CORDIC_GAIN;
            z_in = z_start;
         end
      end else if (busy_ff) begin
         if (!z_ff[ANGLE_W-1]) begin
            x_in = x_ff - y_shift;
            y_in = y_ff + x_shift;
            z_in = z_ff - atan_step;
         end else begin
            x_in = x_ff + y_shift;
            y_in = y_ff - x_shift;
            z_in = z_ff + atan_step;
         end
         iter_in = iter_ff + 1'b1;
         if (iter_ff == IW'(STAGES - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iter_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         iter_ff <= iter_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign done    = done_ff;
   assign cos_out = x_ff;
   assign sin_out = y_ff;

endmodule

`default_nettype wire

>>> hdl/heading_fused_odometry_integrator.sv
// Top level of the heading-fused odometry integrator: sequencer, registers, gating,
// rounding and saturation. Depends on odo_pkg, odo_mul_serial and odo_cordic.
//
//   channel   | handshake                    | payload
//   ----------+------------------------------+---------------------------------------------
//   req       | req_valid / req_ready        | left_count, right_count, heading_angle, fresh
//   rsp       | rsp_valid / rsp_ready        | x_position, y_position, updated
//   csr       | csr_write_enable (no wait)   | csr_index, csr_write_data
//
// One transaction at a time. A fresh transaction after seeding runs in two phases: the
// longer of the CORDIC loop, one rotation a cycle, and the nine-digit path multiplier sets
// the first phase, and the 34-bit serial multipliers, two bits a cycle, set the second.
// Stale and seeding transactions go from the gate state straight to the emit state.
// Reset (synchronous) clears position, stored counts and the seeded flag, and restores
// the register defaults. A stalled result sits in the output register while the next
// request is accepted; the block waits only when a second result is ready first.
`default_nettype none

module heading_fused_odometry_integrator
   import odo_pkg::*;
#(
   parameter int unsigned CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request channel
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic signed [COUNT_W-1:0]     req_left_count,
   input  wire logic signed [COUNT_W-1:0]     req_right_count,
   input  wire logic signed [HEADING_W-1:0]   req_heading_angle,
   input  wire logic                          req_heading_fresh,
   // response channel
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic signed [POS_W-1:0]            rsp_x_position,
   output logic signed [POS_W-1:0]            rsp_y_position,
   output logic                               rsp_updated,
   // register write port
   input  wire logic                          csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0]        csr_index,
   input  wire logic [CSR_DATA_W-1:0]         csr_write_data
);

   // Keep a count delta only when 0 < |delta| < limit
   function automatic logic signed [DELTA_W-1:0] gate_delta(
      input logic [COUNT_W-1:0] cur,
      input logic [COUNT_W-1:0] prev,
      input logic [LIMIT_W-1:0] limit
   );
      logic [COUNT_W-1:0] diff;
      logic [COUNT_W:0]   mag;
      logic signed [DELTA_W-1:0] res;
      diff = cur - prev;
      mag  = diff[COUNT_W-1] ? ((COUNT_W+1)'(0) - {diff[COUNT_W-1], diff}) : {1'b0, diff};
      res  = '0;
      if (diff != '0 && mag < {{(COUNT_W + 1 - LIMIT_W){1'b0}}, limit}) begin
         res = $signed(diff[DELTA_W-1:0]);
      end
      return res;
   endfunction

   odo_state_type state_ff, state_in;

   // Configuration registers
   logic [MPC_W-1:0]   mpc_ff, mpc_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;

   // Captured request
   logic [COUNT_W-1:0]          in_left_ff, in_right_ff;
   logic signed [HEADING_W-1:0] in_heading_ff;
   logic                        in_fresh_ff;

   // Odometry state
   logic [COUNT_W-1:0]      last_left_ff, last_right_ff;
   logic signed [POS_W-1:0] pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic                    seeded_ff;

   // Work registers
   logic signed [DELTA_W-1:0]  dl_ff, dr_ff;
   logic signed [PATH_S_W-1:0] s_ff;
   logic signed [DISP_W-1:0]   dx_ff, dy_ff;
   logic                       upd_ff;

   // Output register
   logic                    rsp_valid_ff;
   logic signed [POS_W-1:0] rsp_x_ff, rsp_y_ff;
   logic                    rsp_upd_ff;

   // Sequencer controls
   logic accept, gate_en, path_go, round_en, proj_go, scale_en, sat_en, emit_load;

   // Unit connections
   logic signed [DSUM_W-1:0]   dsum;
   logic signed [PATH_A_W-1:0] path_a;
   logic signed [PATH_P_W-1:0] path_prod, path_rnd;
   logic signed [PROJ_P_W-1:0] prod_x, prod_y, rnd_x, rnd_y;
   logic signed [TRIG_W-1:0]   cos_val, sin_val;
   logic                       path_done, cordic_done, x_done, y_done;
   logic signed [SUM_W-1:0]    sum_x, sum_y;

   // Sum the gated deltas; the scale rides as a positive signed value
   assign dsum   = $signed({dl_ff[DELTA_W-1], dl_ff}) + $signed({dr_ff[DELTA_W-1], dr_ff});
   assign path_a = $signed({1'b0, mpc_ff});

   odo_mul_serial #(
      .NA (PATH_A_W),
      .NB (DSUM_W)
   ) u_path_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (path_go),
      .a       (path_a),
      .b       (dsum),
      .done    (path_done),
      .product (path_prod)
   );

   odo_cordic #(
      .STAGES (CORDIC_STAGES)
   ) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (path_go),
      .angle   (in_heading_ff),
      .done    (cordic_done),
      .cos_out (cos_val),
      .sin_out (sin_val)
   );

   odo_mul_serial #(
      .NA (TRIG_W),
      .NB (PATH_S_W)
   ) u_x_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (proj_go),
      .a       (cos_val),
      .b       (s_ff),
      .done    (x_done),
      .product (prod_x)
   );

   odo_mul_serial #(
      .NA (TRIG_W),
      .NB (PATH_S_W)
   ) u_y_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (proj_go),
      .a       (sin_val),
      .b       (s_ff),
      .done    (y_done),
      .product (prod_y)
   );

   // Round to nearest by adding half an output step, then drop the low bits
   assign path_rnd = path_prod + PATH_ROUND;
   assign rnd_x    = prod_x + PROJ_ROUND;
   assign rnd_y    = prod_y + PROJ_ROUND;

   // Add displacement and clamp to the signed 32-bit range
   always_comb begin
      sum_x = $signed({{(SUM_W - POS_W){pos_x_ff[POS_W-1]}}, pos_x_ff})
            + $signed({dx_ff[DISP_W-1], dx_ff});
      sum_y = $signed({{(SUM_W - POS_W){pos_y_ff[POS_W-1]}}, pos_y_ff})
            + $signed({dy_ff[DISP_W-1], dy_ff});
      if (sum_x > POS_MAX) begin
         pos_x_in = POS_MAX[POS_W-1:0];
      end else if (sum_x < POS_MIN) begin
         pos_x_in = POS_MIN[POS_W-1:0];
      end else begin
         pos_x_in = sum_x[POS_W-1:0];
      end
      if (sum_y > POS_MAX) begin
         pos_y_in = POS_MAX[POS_W-1:0];
      end else if (sum_y < POS_MIN) begin
         pos_y_in = POS_MIN[POS_W-1:0];
      end else begin
         pos_y_in = sum_y[POS_W-1:0];
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (req_valid) state_in = ST_GATE;
         ST_GATE:     state_in = (in_fresh_ff && seeded_ff) ? ST_PATH_GO : ST_EMIT;
         ST_PATH_GO:  state_in = ST_PATH_RUN;
         ST_PATH_RUN: if (path_done && cordic_done) state_in = ST_ROUND;
         ST_ROUND:    state_in = ST_PROJ_GO;
         ST_PROJ_GO:  state_in = ST_PROJ_RUN;
         ST_PROJ_RUN: if (x_done && y_done) state_in = ST_SCALE;
         ST_SCALE:    state_in = ST_SAT;
         ST_SAT:      state_in = ST_EMIT;
         ST_EMIT:     if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      accept    = req_ready && req_valid;
      gate_en   = (state_ff == ST_GATE);
      path_go   = (state_ff == ST_PATH_GO);
      round_en  = (state_ff == ST_ROUND);
      proj_go   = (state_ff == ST_PROJ_GO);
      scale_en  = (state_ff == ST_SCALE);
      sat_en    = (state_ff == ST_SAT);
      emit_load = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);
   end

   // Register writes; unknown indexes drop
   always_comb begin
      mpc_in   = mpc_ff;
      limit_in = limit_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_METERS_PER_COUNT: mpc_in   = csr_write_data[MPC_W-1:0];
            CSR_COUNT_JUMP_LIMIT: limit_in = csr_write_data[LIMIT_W-1:0];
            default: begin
               mpc_in   = mpc_ff;
               limit_in = limit_ff;
            end
         endcase
      end
   end

   // Control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         mpc_ff        <= MPC_RESET;
         limit_ff      <= LIMIT_RESET;
         last_left_ff  <= '0;
         last_right_ff <= '0;
         pos_x_ff      <= '0;
         pos_y_ff      <= '0;
         seeded_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         mpc_ff   <= mpc_in;
         limit_ff <= limit_in;
         // replace stored counts on any fresh transaction, seed on the first
         if (gate_en && in_fresh_ff) begin
            last_left_ff  <= in_left_ff;
            last_right_ff <= in_right_ff;
            seeded_ff     <= 1'b1;
         end
         if (sat_en) begin
            pos_x_ff <= pos_x_in;
            pos_y_ff <= pos_y_in;
         end
         if (emit_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         in_left_ff    <= req_left_count;
         in_right_ff   <= req_right_count;
         in_heading_ff <= req_heading_angle;
         in_fresh_ff   <= req_heading_fresh;
      end
      if (gate_en) begin
         dl_ff  <= gate_delta(in_left_ff, last_left_ff, limit_ff);
         dr_ff  <= gate_delta(in_right_ff, last_right_ff, limit_ff);
         upd_ff <= 1'b0;
      end
      if (round_en) begin
         s_ff <= path_rnd[PATH_P_W-1:PATH_SHIFT];
      end
      if (scale_en) begin
         dx_ff <= rnd_x[PROJ_P_W-1:PROJ_SHIFT];
         dy_ff <= rnd_y[PROJ_P_W-1:PROJ_SHIFT];
      end
      if (sat_en) begin
         upd_ff <= 1'b1;
      end
      if (emit_load) begin
         rsp_x_ff   <= pos_x_ff;
         rsp_y_ff   <= pos_y_ff;
         rsp_upd_ff <= upd_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_x_position = rsp_x_ff;
   assign rsp_y_position = rsp_y_ff;
   assign rsp_updated    = rsp_upd_ff;

endmodule

`default_nettype wire

>>> hdl/odo_checker.sv
// Port-level checker for the heading-fused odometry integrator, bound to the top level.
// Sees the top level's ports only. Depends on nothing beyond the bound module.
`default_nettype none

module odo_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic signed [31:0] rsp_x_position,
   input wire logic signed [31:0] rsp_y_position,
   input wire logic rsp_updated
);

   // Reset leaves no response pending
   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // One transaction in flight: an accepted request closes the request side
   a_accept_closes_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted back to back");

   // A new response is only produced while the request side is closed
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("response appeared while idle");

   // Hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_x_position) && $stable(rsp_y_position)
          && $stable(rsp_updated)))
      else $error("stalled response changed");

endmodule

bind heading_fused_odometry_integrator odo_checker u_odo_checker (.*);

`default_nettype wire

>>> dv/heading_fused_odometry_integrator_test.sv
// Self-checking testbench for heading_fused_odometry_integrator: directed and random
// odometry readings, predicted pose compared per response. Depends on odo_pkg and the RTL.
module heading_fused_odometry_integrator_test
   import odo_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLOCK_HALF = 10;

   // Fixed-point constants of the pose math
   localparam longint ROTATOR_GAIN  = 652032874;
   localparam longint TURN_QUARTER  = 1073741824;
   localparam longint TURN_HALF     = 64'sd2147483648;
   localparam longint PATH_HALF_LSB = 65536;
   localparam longint PROJ_HALF_LSB = 536870912;
   localparam longint POS_TOP       = 2147483647;
   localparam longint POS_BOTTOM    = -64'sd2147483648;
   localparam longint ARCTAN_TURNS [0:23] = '{
      536870912, 316933405, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335086, 667544, 333772,
      166886, 83443, 41721, 20860, 10430, 5215,
      2607, 1303, 651, 325, 162, 81
   };

   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED      = '1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_UNUSED  = CSR_COUNT_JUMP_LIMIT + 1'b1;

   localparam logic signed [HEADING_W-1:0] HEADING_EAST  = 16'sd0;
   localparam logic signed [HEADING_W-1:0] HEADING_NORTH = 16'sd16384;
   localparam logic signed [HEADING_W-1:0] HEADING_WEST  = -16'sd32768;
   localparam logic signed [HEADING_W-1:0] HEADING_SOUTH = -16'sd16384;

   typedef struct packed {
      logic signed [POS_W-1:0] x_position;
      logic signed [POS_W-1:0] y_position;
      logic                    updated;
   } odo_pose_type;

   // DUT inputs, all known from time zero
   logic                          clock             = 1'b0;
   logic                          reset             = 1'b1;
   logic                          req_valid         = 1'b0;
   logic signed [COUNT_W-1:0]     req_left_count    = '0;
   logic signed [COUNT_W-1:0]     req_right_count   = '0;
   logic signed [HEADING_W-1:0]   req_heading_angle = '0;
   logic                          req_heading_fresh = 1'b0;
   logic                          rsp_ready         = 1'b0;
   logic                          csr_write_enable  = 1'b0;
   logic [CSR_INDEX_W-1:0]        csr_index         = '0;
   logic [CSR_DATA_W-1:0]         csr_write_data    = '0;

   logic                          req_ready;
   logic                          rsp_valid;
   logic signed [POS_W-1:0]       rsp_x_position;
   logic signed [POS_W-1:0]       rsp_y_position;
   logic                          rsp_updated;

   // Predicted block state
   logic [MPC_W-1:0]              est_meters_per_count = MPC_RESET;
   logic [LIMIT_W-1:0]            est_jump_limit       = LIMIT_RESET;
   logic [COUNT_W-1:0]            est_last_left        = '0;
   logic [COUNT_W-1:0]            est_last_right       = '0;
   logic signed [POS_W-1:0]       est_pos_x            = '0;
   logic signed [POS_W-1:0]       est_pos_y            = '0;
   logic                          est_seeded           = 1'b0;

   odo_pose_type                  expected_poses[$];
   int                            mismatch_count     = 0;
   int                            sender_idle_pct    = 0;
   int                            receiver_stall_pct = 0;

   // Encoder and heading as the stimulus sees them
   logic signed [COUNT_W-1:0]     track_left    = '0;
   logic signed [COUNT_W-1:0]     track_right   = '0;
   logic signed [HEADING_W-1:0]   track_heading = '0;

   heading_fused_odometry_integrator i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_left_count    (req_left_count),
      .req_right_count   (req_right_count),
      .req_heading_angle (req_heading_angle),
      .req_heading_fresh (req_heading_fresh),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_x_position    (rsp_x_position),
      .rsp_y_position    (rsp_y_position),
      .rsp_updated       (rsp_updated),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   always #CLOCK_HALF clock = ~clock;

   // ---------------------------------------------------------------- prediction

   // Keep a count delta only when 0 < |delta| < limit
   function automatic longint gated_delta(input logic [COUNT_W-1:0] current,
                                          input logic [COUNT_W-1:0] previous);
      logic signed [COUNT_W-1:0] delta;
      longint                    magnitude;
      delta     = current - previous;
      magnitude = (delta < 0) ? -longint'(delta) : longint'(delta);
      if (magnitude > 0 && magnitude < longint'(est_jump_limit))
         return longint'(delta);
      return 0;
   endfunction

   // Rotation-mode CORDIC: cos and sin in Q1.30 of a 32-bit binary angle
   function automatic void heading_trig(input longint angle, output longint cos_q30,
                                        output longint sin_q30);
      longint x, y, z, x_shift, y_shift;
      x = ROTATOR_GAIN;
      y = 0;
      z = angle;
      // fold the back half-plane onto the front one
      if (z > TURN_QUARTER || z < -TURN_QUARTER) begin
         z = (z > 0) ? z - TURN_HALF : z + TURN_HALF;
         x = -x;
      end
      for (int i = 0; i < CORDIC_STAGES_DEF && i < 24; i++) begin
         x_shift = x >>> i;
         y_shift = y >>> i;
         if (z >= 0) begin
            x = x - y_shift;
            y = y + x_shift;
            z = z - ARCTAN_TURNS[i];
         end else begin
            x = x + y_shift;
            y = y - x_shift;
            z = z + ARCTAN_TURNS[i];
         end
      end
      cos_q30 = x;
      sin_q30 = y;
   endfunction

   function automatic logic signed [POS_W-1:0] saturate_add(input logic signed [POS_W-1:0] pos,
                                                            input longint step);
      longint total;
      total = longint'(pos) + step;
      if (total > POS_TOP)
         return POS_TOP[POS_W-1:0];
      if (total < POS_BOTTOM)
         return POS_BOTTOM[POS_W-1:0];
      return total[POS_W-1:0];
   endfunction

   // Advance the predicted pose by one accepted reading
   function automatic odo_pose_type advance_pose(input logic [COUNT_W-1:0] left,
                                                 input logic [COUNT_W-1:0] right,
                                                 input logic signed [HEADING_W-1:0] heading,
                                                 input logic fresh);
      odo_pose_type pose;
      longint       path_sum, path_len, cos_q30, sin_q30;
      pose.updated = 1'b0;
      if (fresh) begin
         if (est_seeded) begin
            path_sum = gated_delta(left, est_last_left) * longint'(est_meters_per_count)
                     + gated_delta(right, est_last_right) * longint'(est_meters_per_count);
            path_len = (path_sum + PATH_HALF_LSB) >>> 17;
            heading_trig(longint'(heading) * 65536, cos_q30, sin_q30);
            est_pos_x = saturate_add(est_pos_x, (path_len * cos_q30 + PROJ_HALF_LSB) >>> 30);
            est_pos_y = saturate_add(est_pos_y, (path_len * sin_q30 + PROJ_HALF_LSB) >>> 30);
            pose.updated = 1'b1;
         end
         est_seeded     = 1'b1;
         est_last_left  = left;
         est_last_right = right;
      end
      pose.x_position = est_pos_x;
      pose.y_position = est_pos_y;
      return pose;
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic flag_mismatch(input string what);
      mismatch_count++;
      $display("[%0t] mismatch: %s", $time, what);
   endtask

   // Randomly stall the response channel
   always @(posedge clock)
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);

   // Compare each response transaction with the oldest predicted pose
   always @(posedge clock) begin : check_responses
      odo_pose_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_poses.size() == 0) begin
            flag_mismatch("response with no transaction pending");
         end else begin
            want = expected_poses.pop_front();
            if (rsp_x_position !== want.x_position)
               flag_mismatch($sformatf("x_position got %0d want %0d",
                                       rsp_x_position, want.x_position));
            if (rsp_y_position !== want.y_position)
               flag_mismatch($sformatf("y_position got %0d want %0d",
                                       rsp_y_position, want.y_position));
            if (rsp_updated !== want.updated)
               flag_mismatch($sformatf("updated got %0b want %0b",
                                       rsp_updated, want.updated));
         end
      end
   end

   // ---------------------------------------------------------------- driving

   // Present one reading, hold it until accepted, then predict its pose
   task automatic send_reading(input logic signed [COUNT_W-1:0] left,
                               input logic signed [COUNT_W-1:0] right,
                               input logic signed [HEADING_W-1:0] heading,
                               input logic fresh);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_left_count    <= left;
      req_right_count   <= right;
      req_heading_angle <= heading;
      req_heading_fresh <= fresh;
      do @(posedge clock); while (!req_ready);
      expected_poses.push_back(advance_pose(left, right, heading, fresh));
   endtask

   // Fresh reading with the wheels advanced by the given counts
   task automatic move_wheels(input int left_step, input int right_step,
                              input logic signed [HEADING_W-1:0] heading);
      track_left  = track_left + left_step;
      track_right = track_right + right_step;
      send_reading(track_left, track_right, heading, 1'b1);
   endtask

   // Fresh reading at absolute counts
   task automatic jump_counts(input logic signed [COUNT_W-1:0] left,
                              input logic signed [COUNT_W-1:0] right,
                              input logic signed [HEADING_W-1:0] heading);
      track_left  = left;
      track_right = right;
      send_reading(left, right, heading, 1'b1);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(posedge clock);
      case (index)
         CSR_METERS_PER_COUNT: est_meters_per_count = data;
         CSR_COUNT_JUMP_LIMIT: est_jump_limit       = data[LIMIT_W-1:0];
         default: ;
      endcase
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // Drop valid and wait until every predicted pose has come back
   task automatic settle(input int extra_cycles);
      req_valid <= 1'b0;
      while (expected_poses.size() != 0)
         @(posedge clock);
      repeat (extra_cycles) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- tests

   // Stale readings before and after the seeding reading, then a first motion
   task automatic test_stale_and_seeding;
      send_reading(32'sd1000, -32'sd5000, HEADING_NORTH, 1'b0);
      jump_counts(32'sd100, 32'sd200, HEADING_EAST);
      send_reading($urandom, $urandom, HEADING_W'($urandom), 1'b0);
      move_wheels(50, 70, HEADING_EAST);
      // fresh but standing still
      move_wheels(0, 0, 16'sd4096);
   endtask

   // Deltas at the jump limit, wraparound and the most negative delta
   task automatic test_count_gating;
      move_wheels(int'(LIMIT_RESET) - 1, -(int'(LIMIT_RESET) - 1), HEADING_EAST);
      move_wheels(int'(LIMIT_RESET), -int'(LIMIT_RESET), HEADING_EAST);
      move_wheels(1, -1, 16'sd8192);
      jump_counts(32'sh7FFF_FFF0, 32'sh8000_0005, HEADING_EAST);
      move_wheels(32, -32, HEADING_EAST);
      jump_counts('0, '0, HEADING_EAST);
      jump_counts(32'sh8000_0000, 32'sh8000_0000, HEADING_EAST);
      jump_counts(32'sh7FFF_FFFF, 32'sh8000_0000, HEADING_EAST);
   endtask

   // Heading at both ends of its range and around the quarter turns
   task automatic test_heading_extremes;
      move_wheels(400, 400, HEADING_WEST);
      move_wheels(400, 400, 16'sh7FFF);
      move_wheels(400, 400, HEADING_NORTH);
      move_wheels(400, 400, HEADING_NORTH + 1'b1);
      move_wheels(400, 400, HEADING_SOUTH);
      move_wheels(400, 400, HEADING_SOUTH - 1'b1);
      move_wheels(400, 400, HEADING_EAST);
   endtask

   // Zero scale, ignored register index and a jump limit of zero
   task automatic test_register_extremes;
      settle(4);
      write_register(CSR_METERS_PER_COUNT, '0);
      move_wheels(500, 500, HEADING_EAST);
      settle(4);
      write_register(CSR_UNMAPPED, '1);
      move_wheels(500, -200, HEADING_NORTH);
      settle(4);
      write_register(CSR_COUNT_JUMP_LIMIT, '0);
      write_register(CSR_METERS_PER_COUNT, '1);
      move_wheels(10, -3, 16'sd1000);
   endtask

   // Largest scale and limit: drive each position into both rails
   task automatic test_position_saturation;
      settle(4);
      write_register(CSR_METERS_PER_COUNT, '1);
      write_register(CSR_COUNT_JUMP_LIMIT, '1);
      move_wheels(65534, 65534, HEADING_EAST);
      move_wheels(65534, 65534, HEADING_NORTH);
      move_wheels(65534, 65534, HEADING_WEST);
      move_wheels(65534, 65534, HEADING_SOUTH);
      move_wheels(-65534, -65534, HEADING_EAST);
   endtask

   // Mostly smooth driving with random content, plus stale, jump and boundary noise
   task automatic test_random_traffic(input int item_count, input int idle_pct,
                                      input int stall_pct, input logic [MPC_W-1:0] scale,
                                      input logic [LIMIT_W-1:0] limit);
      int pick, span, left_step, right_step;
      settle(4);
      write_register(CSR_METERS_PER_COUNT, scale);
      write_register(CSR_COUNT_JUMP_LIMIT, limit);
      write_register(CSR_INDEX_W'($urandom_range(CSR_UNMAPPED, CSR_FIRST_UNUSED)), $urandom);
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      repeat (item_count) begin
         pick = $urandom_range(99);
         if (pick < 10) begin
            send_reading($urandom, $urandom, HEADING_W'($urandom), 1'b0);
         end else if (pick < 16) begin
            jump_counts($urandom, $urandom, HEADING_W'($urandom));
         end else begin
            if (pick < 24) begin
               // right at or just inside the jump limit
               left_step  = ($urandom_range(1) ? 1 : -1) * (int'(limit) - int'($urandom_range(1)));
               right_step = ($urandom_range(1) ? 1 : -1) * (int'(limit) - int'($urandom_range(1)));
            end else begin
               span       = (pick < 35) ? int'(limit) : 64;
               left_step  = int'($urandom_range(2 * span)) - span;
               right_step = int'($urandom_range(2 * span)) - span;
            end
            if ($urandom_range(3) == 0)
               track_heading = HEADING_W'($urandom);
            else
               track_heading = track_heading + HEADING_W'(int'($urandom_range(1024)) - 512);
            move_wheels(left_step, right_step, track_heading);
         end
      end
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_stale_and_seeding;
      test_count_gating;
      test_heading_extremes;
      test_register_extremes;
      test_position_saturation;

      test_random_traffic(420, 0, 0, MPC_RESET, LIMIT_RESET);
      test_random_traffic(420, 82, 0, $urandom_range(200000),
                          LIMIT_W'($urandom_range(65535, 1)));
      test_random_traffic(420, 0, 82, $urandom, LIMIT_W'($urandom_range(2000, 1)));
      test_random_traffic(420, 38, 38, $urandom_range(5000000),
                          LIMIT_W'($urandom_range(65535, 1)));

      // drain, then watch for stray responses
      req_valid <= 1'b0;
      for (int n = 0; n < 20000 && expected_poses.size() != 0; n++)
         @(posedge clock);
      repeat (60) @(posedge clock);
      if (expected_poses.size() != 0)
         flag_mismatch($sformatf("%0d responses never arrived", expected_poses.size()));

      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // Hard stop if the block hangs
   initial begin
      #60ms;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
